[rtl/core/efd_pkg.sv]
// efd_pkg: shared types and constants of the escaped frame deframer
// used by efd_front, efd_back and escaped_frame_deframer; no dependencies
`default_nettype none

package efd_pkg;

	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned INDEX_W       = 10;
	localparam int unsigned LEN_W         = 16;
	localparam int unsigned CFG_IDX_W     = 2;

	// default sizes of the frame buffer and the frame limit
	localparam int unsigned BUFFER_BYTES_DEF    = 1024;
	localparam int unsigned MAX_FRAME_BYTES_DEF = 512;

	// result queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_VALUE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CODE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LITERAL_CODE   = 2'd3;

	// reset values of the configuration registers
	localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RST = 8'd1;
	localparam logic [BYTE_W-1:0] ESCAPE_VALUE_RST   = 8'd153;
	localparam logic [BYTE_W-1:0] START_CODE_RST     = 8'd1;
	localparam logic [BYTE_W-1:0] LITERAL_CODE_RST   = 8'd85;

	localparam logic [BYTE_W-1:0] BROADCAST_ADDRESS = 8'd0;

	typedef struct packed {
		logic [BYTE_W-1:0] escape_value;
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] literal_code;
	} efd_cfg_t;

	// one payload byte on its way from front to back
	typedef struct packed {
		logic [BYTE_W-1:0]  payload_byte;
		logic [INDEX_W-1:0] byte_index;
		logic [BYTE_W-1:0]  frame_command;
		logic               last_byte;
		logic [BYTE_W-1:0]  frame_address;
	} efd_entry_t;

endpackage

`default_nettype wire

[rtl/core/efd_front.sv]
// efd_front: accepts received bytes, runs the escape and header parser
// and pushes one entry per payload byte; depends on efd_pkg
`default_nettype none

module efd_front
	import efd_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES    = BUFFER_BYTES_DEF,
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire efd_cfg_t          cfg,
	input  wire logic              space,
	output logic                   push,
	output efd_entry_t             entry
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ESCAPE  = 3'd1;
	localparam logic [2:0] PH_ADDRESS = 3'd2;
	localparam logic [2:0] PH_HEADER  = 3'd3;
	localparam logic [2:0] PH_RECEIVE = 3'd4;

	localparam logic [LEN_W:0] LEN_CAP = (LEN_W+1)'(BUFFER_BYTES - 1);
	localparam logic [LEN_W:0] LEN_MAX = (LEN_W+1)'(MAX_FRAME_BYTES);

	logic [2:0]         phase_q, phase_d;
	logic [2:0]         resume_q, resume_d;
	logic [BYTE_W-1:0]  addr_q, addr_d;
	logic [INDEX_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0]  cmd_q, cmd_d;
	logic [LEN_W-1:0]   len_q, len_d;

	logic              accept;
	logic              is_esc, is_start, is_lit;
	logic              do_hdr, do_pay, last;
	logic [BYTE_W-1:0] data_b;
	logic [LEN_W-1:0]  len_raw, len_cl;

	assign in_ready = space;
	assign accept   = in_valid && space;
	assign is_esc   = (rx_byte == cfg.escape_value);
	assign is_start = (rx_byte == cfg.start_code);
	assign is_lit   = (rx_byte == cfg.literal_code);

	assign len_raw = {data_b, len_q[BYTE_W-1:0]};
	assign len_cl  = ({1'b0, len_raw} > LEN_CAP) ? LEN_CAP[LEN_W-1:0] : len_raw;
	assign last    = (len_q == '0) ||
		!({{(LEN_W-INDEX_W){1'b0}}, count_q} < (len_q - LEN_W'(1)));

	always_comb begin
		phase_d  = phase_q;
		resume_d = resume_q;
		addr_d   = addr_q;
		count_d  = count_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		do_hdr   = 1'b0;
		do_pay   = 1'b0;
		data_b   = rx_byte;

		case (phase_q)
			PH_IDLE: begin
				if (is_esc) begin
					resume_d = PH_IDLE;
					phase_d  = PH_ESCAPE;
				end
			end
			PH_ESCAPE: begin
				if (is_start) begin
					phase_d = PH_ADDRESS;
				end else if (is_lit) begin
					// repaired literal: the escape value itself is the data
					data_b = cfg.escape_value;
					if (resume_q == PH_HEADER) begin
						phase_d = PH_HEADER;
						do_hdr  = 1'b1;
					end else if (resume_q == PH_RECEIVE) begin
						phase_d = PH_RECEIVE;
						do_pay  = 1'b1;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_ADDRESS: begin
				addr_d  = rx_byte;
				count_d = '0;
				phase_d = PH_HEADER;
			end
			PH_HEADER: begin
				if (is_esc) begin
					resume_d = PH_HEADER;
					phase_d  = PH_ESCAPE;
				end else begin
					do_hdr = 1'b1;
				end
			end
			PH_RECEIVE: begin
				if (is_esc) begin
					resume_d = PH_RECEIVE;
					phase_d  = PH_ESCAPE;
				end else begin
					do_pay = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (do_hdr) begin
			if (count_q == INDEX_W'(0)) begin
				cmd_d   = data_b;
				count_d = INDEX_W'(1);
			end else if (count_q == INDEX_W'(1)) begin
				len_d   = {{(LEN_W-BYTE_W){1'b0}}, data_b};
				count_d = INDEX_W'(2);
			end else begin
				len_d = len_cl;
				if ({1'b0, len_cl} > LEN_MAX) begin
					phase_d = PH_IDLE;
				end else begin
					count_d = '0;
					phase_d = PH_RECEIVE;
				end
			end
		end

		if (do_pay) begin
			if (last) begin
				phase_d = PH_IDLE;
			end else begin
				count_d = count_q + INDEX_W'(1);
			end
		end
	end

	assign push                = accept && do_pay;
	assign entry.payload_byte  = data_b;
	assign entry.byte_index    = count_q;
	assign entry.frame_command = cmd_q;
	assign entry.last_byte     = last;
	assign entry.frame_address = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			resume_q <= PH_IDLE;
			addr_q   <= '0;
			count_q  <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			resume_q <= resume_d;
			addr_q   <= addr_d;
			count_q  <= count_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
		end
	end

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (in_valid && in_ready))
		else $error("entry pushed without an input transfer");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(push && entry.last_byte) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after last payload byte");

	a_push_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (phase_q == PH_RECEIVE ||
			(phase_q == PH_ESCAPE && resume_q == PH_RECEIVE)))
		else $error("payload byte pushed outside payload phase");

endmodule

`default_nettype wire

[rtl/core/efd_back.sv]
// efd_back: short result queue and output formatting with address match
// depends on efd_pkg
`default_nettype none

module efd_back
	import efd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire efd_entry_t         entry,
	output logic                    space,
	input  wire logic [BYTE_W-1:0]  device_address,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [BYTE_W-1:0]       payload_byte,
	output logic [INDEX_W-1:0]      byte_index,
	output logic [BYTE_W-1:0]       frame_command,
	output logic                    last_byte,
	output logic                    for_this_device
);

	efd_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               pop;
	efd_entry_t         head;

	assign space     = (count_q < QCNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];

	assign payload_byte    = head.payload_byte;
	assign byte_index      = head.byte_index;
	assign frame_command   = head.frame_command;
	assign last_byte       = head.last_byte;
	assign for_this_device = head.last_byte &&
		((head.frame_address == device_address) ||
		 (head.frame_address == BROADCAST_ADDRESS));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("push into full result queue");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - QCNT_W'(1)))
		else $error("queue count not reduced by a transfer");

endmodule

`default_nettype wire

[rtl/core/escaped_frame_deframer.sv]
// escaped_frame_deframer: top level of the escape-byte framing deframer
// depends on efd_pkg, efd_front and efd_back
`default_nettype none

// usage
//  - input channel (in_valid / in_ready / rx_byte): one raw link byte per transfer
//  - output channel (out_valid / out_ready / payload fields): one unescaped
//    payload byte per transfer with its index and the frame command;
//    last_byte marks the end of a frame, for_this_device is set on it when
//    the frame address is device_address or the broadcast address 0
//  - config port (cfg_we / cfg_index / cfg_data): write-only, one register
//    per cycle, to be written while no frame bytes are in flight
//  - throughput: one byte per cycle while in_ready is high; the parser decides
//    each byte combinationally, so header and escape bytes are accepted at that rate too
//  - output: a payload byte is presented on the output at the earliest the
//    cycle after its transfer; it comes from a 4-entry queue in the back part
//  - receiver stall: the queue absorbs up to 4 payload bytes, after that
//    in_ready drops until the receiver takes one; header and escape bytes
//    are accepted only while the queue has room
//  - reset: parser back to idle, queue empty, registers at their defaults
//    (address 1, escape 153, start code 1, literal code 85)
module escaped_frame_deframer
	import efd_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES    = BUFFER_BYTES_DEF,
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// byte input
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	// payload output
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [BYTE_W-1:0]         payload_byte,
	output logic [INDEX_W-1:0]        byte_index,
	output logic [BYTE_W-1:0]         frame_command,
	output logic                      last_byte,
	output logic                      for_this_device,
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	logic [BYTE_W-1:0] device_address_q;
	logic [BYTE_W-1:0] escape_value_q;
	logic [BYTE_W-1:0] start_code_q;
	logic [BYTE_W-1:0] literal_code_q;

	efd_cfg_t   cfg;
	efd_entry_t entry;
	logic       push;
	logic       space;

	// configuration registers, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEVICE_ADDRESS_RST;
			escape_value_q   <= ESCAPE_VALUE_RST;
			start_code_q     <= START_CODE_RST;
			literal_code_q   <= LITERAL_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				CFG_ESCAPE_VALUE:   escape_value_q   <= cfg_data;
				CFG_START_CODE:     start_code_q     <= cfg_data;
				CFG_LITERAL_CODE:   literal_code_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.escape_value = escape_value_q;
	assign cfg.start_code   = start_code_q;
	assign cfg.literal_code = literal_code_q;

	// front: escape handling, header parse, payload indexing
	efd_front #(
		.BUFFER_BYTES    (BUFFER_BYTES),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.space    (space),
		.push     (push),
		.entry    (entry)
	);

	// back: result queue and address match on the last byte
	efd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.entry           (entry),
		.space           (space),
		.device_address  (device_address_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.payload_byte    (payload_byte),
		.byte_index      (byte_index),
		.frame_command   (frame_command),
		.last_byte       (last_byte),
		.for_this_device (for_this_device)
	);

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for escaped_frame_deframer, predicts every payload transfer
// depends on efd_pkg and the escaped_frame_deframer rtl

module testbench;
	import efd_pkg::*;

	localparam int unsigned CLK_HALF     = 6;
	localparam int unsigned RESET_CYCLES = 6;
	localparam int unsigned DRAIN_CYCLES = 8;      // extra wait once no transfer is predicted any more
	localparam int unsigned HOLD_CYCLES  = 150;    // long receiver hold-off
	localparam int unsigned REPORT_LIMIT = 10;
	localparam longint unsigned WATCHDOG_NS = 64'd2_000_000;

	// parser phases of the predictor
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESCAPE,
		PH_ADDRESS,
		PH_HEADER,
		PH_RECEIVE
	} parse_phase_t;

	// one payload transfer as seen on the output channel
	typedef struct packed {
		logic [BYTE_W-1:0]  payload_byte;
		logic [INDEX_W-1:0] byte_index;
		logic [BYTE_W-1:0]  frame_command;
		logic               last_byte;
		logic               for_this_device;
	} payload_rec_t;

	// dut ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    payload_byte;
	logic [INDEX_W-1:0]   byte_index;
	logic [BYTE_W-1:0]    frame_command;
	logic                 last_byte;
	logic                 for_this_device;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	// deframer predictor: register copies and parser state
	logic [BYTE_W-1:0]  m_dev     = DEVICE_ADDRESS_RST;
	logic [BYTE_W-1:0]  m_escape  = ESCAPE_VALUE_RST;
	logic [BYTE_W-1:0]  m_start   = START_CODE_RST;
	logic [BYTE_W-1:0]  m_literal = LITERAL_CODE_RST;
	parse_phase_t       m_phase   = PH_IDLE;
	parse_phase_t       m_resume  = PH_IDLE;
	logic [BYTE_W-1:0]  m_address = '0;
	logic [INDEX_W-1:0] m_count   = '0;
	logic [BYTE_W-1:0]  m_command = '0;
	logic [LEN_W-1:0]   m_length  = '0;

	payload_rec_t      expected_payload_q[$];   // predicted transfers not yet seen
	logic [BYTE_W-1:0] link_q[$];               // raw link bytes waiting to go out

	int unsigned items_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatches    = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        hold_output   = 1'b0;

	escaped_frame_deframer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.payload_byte    (payload_byte),
		.byte_index      (byte_index),
		.frame_command   (frame_command),
		.last_byte       (last_byte),
		.for_this_device (for_this_device),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// header bytes: command, length low, length high
	task automatic take_header_byte(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] len;
		if (m_count == 0) begin
			m_command = b;
			m_count   = 1;
		end else if (m_count == 1) begin
			m_length = LEN_W'(b);
			m_count  = 2;
		end else begin
			// little-endian length, clamped to the buffer, dropped above the frame limit
			len = m_length + (LEN_W'(b) << 8);
			if (len > BUFFER_BYTES_DEF - 1)
				len = LEN_W'(BUFFER_BYTES_DEF - 1);
			m_length = len;
			if (len > MAX_FRAME_BYTES_DEF) begin
				m_phase = PH_IDLE;
			end else begin
				m_count = 0;
				m_phase = PH_RECEIVE;
			end
		end
	endtask

	// payload byte: always one transfer, the last one closes the frame
	task automatic take_payload_byte(input logic [BYTE_W-1:0] b, output payload_rec_t rec);
		logic [INDEX_W-1:0] idx;
		logic               last;
		idx  = m_count;
		// a zero length acts like a length of one
		last = !(m_length != 0 && idx < m_length - 1);
		rec.payload_byte    = b;
		rec.byte_index      = idx;
		rec.frame_command   = m_command;
		rec.last_byte       = last;
		rec.for_this_device = last && (m_address == m_dev || m_address == BROADCAST_ADDRESS);
		if (last)
			m_phase = PH_IDLE;
		else
			m_count = idx + 1'b1;
	endtask

	// one accepted link byte, emits tells whether a transfer follows
	task automatic deframe_byte(input logic [BYTE_W-1:0] b, output bit emits,
			output payload_rec_t rec);
		emits = 1'b0;
		rec   = '0;
		case (m_phase)
			PH_IDLE: begin
				if (b == m_escape) begin
					m_resume = PH_IDLE;
					m_phase  = PH_ESCAPE;
				end
			end
			PH_ESCAPE: begin
				// start code wins over the literal code when the two are equal
				if (b == m_start) begin
					m_phase = PH_ADDRESS;
				end else if (b == m_literal) begin
					m_phase = m_resume;
					if (m_phase == PH_HEADER) begin
						take_header_byte(m_escape);
					end else if (m_phase == PH_RECEIVE) begin
						take_payload_byte(m_escape, rec);
						emits = 1'b1;
					end else begin
						m_phase = PH_IDLE;
					end
				end
				// any other byte keeps the escape phase
			end
			PH_ADDRESS: begin
				// address taken raw, even if it equals the escape value
				m_address = b;
				m_count   = 0;
				m_phase   = PH_HEADER;
			end
			PH_HEADER: begin
				if (b == m_escape) begin
					m_resume = PH_HEADER;
					m_phase  = PH_ESCAPE;
				end else begin
					take_header_byte(b);
				end
			end
			PH_RECEIVE: begin
				if (b == m_escape) begin
					m_resume = PH_RECEIVE;
					m_phase  = PH_ESCAPE;
				end else begin
					take_payload_byte(b, rec);
					emits = 1'b1;
				end
			end
			default: begin
				m_phase = PH_IDLE;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------

	// offer one link byte, predict its effect once the transfer happens
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		payload_rec_t rec;
		bit           emits;
		// each cycle idles with the set chance before the byte is offered
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		deframe_byte(b, emits, rec);
		if (emits)
			expected_payload_q.push_back(rec);
	endtask

	task automatic send_link();
		while (link_q.size() != 0)
			send_byte(link_q.pop_front());
	endtask

	// a data byte equal to the escape value goes out as escape plus literal code
	function automatic void put_escaped(input logic [BYTE_W-1:0] b);
		link_q.push_back(b);
		if (b == m_escape) begin
			link_q.pop_back();
			link_q.push_back(m_escape);
			link_q.push_back(m_literal);
		end
	endfunction

	// frame with n_data unescaped payload bytes, fewer than the length gives a cut frame
	function automatic void put_frame(input logic [BYTE_W-1:0] addr,
			input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] len,
			input int unsigned n_data);
		logic [BYTE_W-1:0] d;
		link_q.push_back(m_escape);
		link_q.push_back(m_start);
		link_q.push_back(addr);
		put_escaped(cmd);
		put_escaped(len[7:0]);
		put_escaped(len[15:8]);
		repeat (n_data) begin
			d = ($urandom_range(7) == 0) ? m_escape : BYTE_W'($urandom_range(255));
			put_escaped(d);
		end
	endfunction

	// sender stops and waits until every predicted transfer is through
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_payload_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// all four registers, only while the block is idle
	task automatic set_config(input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] esc,
			input logic [BYTE_W-1:0] start, input logic [BYTE_W-1:0] lit);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [BYTE_W-1:0]    val[4];
		idx = '{CFG_DEVICE_ADDRESS, CFG_ESCAPE_VALUE, CFG_START_CODE, CFG_LITERAL_CODE};
		val = '{dev, esc, start, lit};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		m_dev     = dev;
		m_escape  = esc;
		m_start   = start;
		m_literal = lit;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// receiver and checker
	// ------------------------------------------------------------------

	function automatic string rec_text(input payload_rec_t r);
		return $sformatf("byte %02h index %0d command %02h last %0b device %0b",
			r.payload_byte, r.byte_index, r.frame_command, r.last_byte, r.for_this_device);
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// random ready, held low during a hold-off, compare each output transfer
	always @(posedge clk) begin : take_result
		payload_rec_t got;
		payload_rec_t want;
		out_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			got = '{payload_byte, byte_index, frame_command, last_byte, for_this_device};
			if (expected_payload_q.size() == 0) begin
				note_mismatch($sformatf("transfer %0d not predicted: %s", results_seen,
					rec_text(got)));
			end else begin
				want = expected_payload_q.pop_front();
				if (got !== want)
					note_mismatch($sformatf("transfer %0d expected %s, got %s", results_seen,
						rec_text(want), rec_text(got)));
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-built byte sequences at the reset register values
	task automatic test_directed_cases();
		logic [BYTE_W-1:0] e, s, l;
		e = m_escape;
		s = m_start;
		l = m_literal;
		link_q = {
			// escape then literal code while idle: back to idle, nothing out
			e, l,
			// broadcast frame, length zero acts as one byte, extreme bytes
			e, s, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
			// a second escape keeps the escape phase, then start
			e, e, s,
			// raw escape value as address, escaped command, stray code after escape,
			// escaped payload byte, then a start that cuts the frame
			e, e, l, 8'h03, 8'h00, 8'h00, e, 8'h07, l, e, s,
			// oversized length: clamped and dropped
			8'h01, 8'h5A, 8'hFF, 8'hFF,
			// frame for this device with two bytes
			e, s, 8'h01, 8'h00, 8'h02, 8'h00, 8'h80, 8'h7F
		};
		send_link();
	endtask

	// mostly well-formed frames with random content, some cut, stray or noise
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned       first;
		int unsigned       kind;
		int unsigned       n_data;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
		first = items_sent;
		while (items_sent - first < n_items) begin
			case ($urandom_range(2))
				0: addr = BROADCAST_ADDRESS;
				1: addr = m_dev;
				default: addr = BYTE_W'($urandom_range(255));
			endcase
			cmd  = BYTE_W'($urandom_range(255));
			kind = $urandom_range(99);
			if (kind < 70)
				len = LEN_W'($urandom_range(0, 8));
			else if (kind < 88)
				len = LEN_W'($urandom_range(9, 40));
			else if (kind < 92)
				len = LEN_W'(MAX_FRAME_BYTES_DEF + 1);
			else if (kind < 95)
				len = '1;
			else
				len = LEN_W'($urandom_range(MAX_FRAME_BYTES_DEF + 1, 65535));
			n_data = (len > MAX_FRAME_BYTES_DEF) ? 0 : ((len == 0) ? 1 : len);
			kind = $urandom_range(99);
			if (kind < 75) begin
				put_frame(addr, cmd, len, n_data);
			end else if (kind < 87) begin
				// cut frame, the next start aborts it
				put_frame(addr, cmd, len, $urandom_range(0, n_data));
			end else if (kind < 93) begin
				// escape followed by an arbitrary byte inside a frame
				put_frame(addr, cmd, len, $urandom_range(0, n_data));
				link_q.push_back(m_escape);
				link_q.push_back(BYTE_W'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 6))
					link_q.push_back(BYTE_W'($urandom_range(255)));
			end
			send_link();
		end
	endtask

	// receiver stops for a long stretch while the sender keeps offering,
	// then the sender waits until everything has drained
	task automatic test_backpressure();
		fork
			begin
				hold_output <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output <= 1'b0;
			end
		join_none
		put_frame(m_dev, BYTE_W'($urandom_range(255)), 40, 40);
		send_link();
		wait_drained();
	endtask

	// longest frame the limit lets through
	task automatic test_max_frame();
		put_frame(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
			LEN_W'(MAX_FRAME_BYTES_DEF), MAX_FRAME_BYTES_DEF);
		send_link();
	endtask

	// start code equal to literal code: the escape sequence starts a frame
	task automatic test_start_equals_literal();
		logic [BYTE_W-1:0] e, c;
		wait_drained();
		set_config(8'h10, ESCAPE_VALUE_RST, 8'h42, 8'h42);
		e = m_escape;
		c = m_start;
		link_q = {
			e, c, 8'h05, 8'h10, 8'h01, 8'h00,
			// inside the payload this must restart, not insert a literal
			e, c, 8'h10, 8'h11, 8'h00, 8'h00, 8'hAA
		};
		send_link();
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values, sender rarely idle, receiver often stalls
		send_idle_pct = 9;
		recv_idle_pct <= 68;
		test_directed_cases();
		test_random_traffic(190);
		test_backpressure();

		// register extremes, roles of the two sides swapped
		wait_drained();
		set_config(8'hFF, 8'h00, 8'hFF, 8'h00);
		send_idle_pct = 68;
		recv_idle_pct <= 9;
		test_random_traffic(190);

		// other extremes, no idling on either side
		wait_drained();
		set_config(8'h00, 8'hFF, 8'h00, 8'hAA);
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		test_max_frame();
		test_random_traffic(190);
		test_start_equals_literal();

		wait_drained();
		if (mismatches == 0 && expected_payload_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#(WATCHDOG_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
